// ===== design/rrt_pkg.sv =====
// Shared types, constants and helpers for the RRT tree extend engine.
// Used by rrt_sqrt, rrt_div and the top level; no dependencies.
package rrt_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int MAX_BOXES = 16;
  localparam int BOX_AW    = $clog2(MAX_BOXES);
  localparam int BCNT_W    = BOX_AW + 1;
  localparam int COORD_W   = 12;
  localparam int COST_W    = 32;
  localparam int D2_W      = 2 * COORD_W + 1;
  localparam int PROD_W    = 2 * (COORD_W + 1);

  // square root unit: radicand sized for d2 shifted up by 16 (Q8 result)
  localparam int SQ_IN_W   = 2 * ((D2_W + 16 + 1) / 2);
  localparam int SQ_OUT_W  = SQ_IN_W / 2;
  localparam int SQ_CNT_W  = $clog2(SQ_OUT_W + 1);

  // divider for the growth offset
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = SQ_OUT_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic [COORD_W:0] COORD_SPAN = 13'd4096;
  localparam logic [CNT_W-1:0] GOAL_SAT   = 11'd2047;

  // commands
  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_BOX     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // status codes
  localparam logic [3:0] ST_ADDED    = 4'd0;
  localparam logic [3:0] ST_CLOSE    = 4'd1;
  localparam logic [3:0] ST_OFFMAP   = 4'd2;
  localparam logic [3:0] ST_COLLIDE  = 4'd3;
  localparam logic [3:0] ST_FULL     = 4'd4;
  localparam logic [3:0] ST_BOX_OK   = 4'd5;
  localparam logic [3:0] ST_BOX_FULL = 4'd6;
  localparam logic [3:0] ST_RESTART  = 4'd7;
  localparam logic [3:0] ST_EMPTY    = 4'd8;

  // configuration register indexes
  localparam logic [2:0] CFG_MAP_W   = 3'd0;
  localparam logic [2:0] CFG_MAP_H   = 3'd1;
  localparam logic [2:0] CFG_STEP    = 3'd2;
  localparam logic [2:0] CFG_START_X = 3'd3;
  localparam logic [2:0] CFG_START_Y = 3'd4;
  localparam logic [2:0] CFG_GOAL_X  = 3'd5;
  localparam logic [2:0] CFG_GOAL_Y  = 3'd6;
  localparam logic [2:0] CFG_STAR    = 3'd7;

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [IDX_W-1:0]   parent;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } node_t;

  typedef struct packed {
    logic [COORD_W-1:0] y2;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x1;
  } box_t;

  localparam int NODE_W = $bits(node_t);
  localparam int BOX_W  = $bits(box_t);

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [SQ_OUT_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W + 1 - SQ_OUT_W){1'b0}}, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

// ===== design/rrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rrt_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on rrt_pkg.
module rrt_sqrt import rrt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_IN_W-1:0]  x;
  logic [SQ_OUT_W+2:0] rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic                busy;
  logic [SQ_OUT_W+2:0] rem_sh;
  logic [SQ_OUT_W+2:0] trial;
  logic                ge;

  assign rem_sh = {rem[SQ_OUT_W:0], x[SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[SQ_IN_W-3:0], 2'b00};
        if (ge) begin
          rem  <= rem_sh - trial;
          root <= {root[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SQ_OUT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == SQ_CNT_W'(SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/rrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rrt_pkg.
module rrt_div import rrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_N_W-1:0]   dividend,
  input  logic [DIV_D_W-1:0]   divisor,
  output logic                 done,
  output logic [DIV_N_W-1:0]   quotient
);

  logic [DIV_D_W-1:0]   dvs;
  logic [DIV_D_W:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_D_W:0]     rem_sh;
  logic                 ge;

  // quotient register doubles as the dividend shifter
  assign rem_sh = {rem[DIV_D_W-1:0], quotient[DIV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        rem      <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
        quotient <= {quotient[DIV_N_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/rrt_tree_extend_engine.sv =====
// Top level: sequencer, shared multiplier, tree and box memories.
// Depends on rrt_pkg, rrt_ram, rrt_sqrt, rrt_div.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata items, s_tuser command
//  m_      | out | m_tvalid/m_tready  | m_tdata result, m_tuser status
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Box load and restart are handled directly by the dispatcher. A sample runs a nearest scan
// over the stored nodes, a growth-length root, the two growth divides, a check of each stored
// box, the cost root, and with RRT* on a neighbour pass (a second pass only when a cheaper
// parent is found) with a root per neighbour. The single root unit and one RAM read port
// serialise this work; s_tready is low while an item is in work. Reset is synchronous; the
// tree reads as empty until a restart.
module rrt_tree_extend_engine import rrt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // px, py, box_x_end, box_y_end
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // node_index, node_x, node_y, parent,
                                  // node_cost, rewired_count, goal_hit,
                                  // best_goal_index, best_goal_cost, goal_count
  output logic [3:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_MX    = 5'd3;
  localparam logic [4:0] S_MY    = 5'd4;
  localparam logic [4:0] S_EVAL  = 5'd5;
  localparam logic [4:0] S_NSW   = 5'd6;
  localparam logic [4:0] S_NEXT  = 5'd7;
  localparam logic [4:0] S_CLOSE = 5'd8;
  localparam logic [4:0] S_QW    = 5'd9;
  localparam logic [4:0] S_GMUL  = 5'd10;
  localparam logic [4:0] S_GDIV  = 5'd11;
  localparam logic [4:0] S_GDW   = 5'd12;
  localparam logic [4:0] S_BRD   = 5'd13;
  localparam logic [4:0] S_BCHK  = 5'd14;
  localparam logic [4:0] S_CSQ   = 5'd15;
  localparam logic [4:0] S_CSW   = 5'd16;
  localparam logic [4:0] S_TMUL  = 5'd17;
  localparam logic [4:0] S_STORE = 5'd18;
  localparam logic [4:0] S_GX    = 5'd19;
  localparam logic [4:0] S_GY    = 5'd20;
  localparam logic [4:0] S_GS    = 5'd21;
  localparam logic [4:0] S_GCHK  = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  localparam logic [1:0] P_NEAR = 2'd0;
  localparam logic [1:0] P_PAR  = 2'd1;
  localparam logic [1:0] P_WIRE = 2'd2;

  logic [4:0] state;

  // configuration
  logic [COORD_W:0]   map_w, map_h;
  logic [COORD_W-1:0] step, start_x, start_y, goal_x, goal_y;
  logic               star_en;

  // item
  logic [1:0]         cmd;
  logic [COORD_W-1:0] px, py, bxe, bye;

  // persistent state
  logic [CNT_W-1:0]   tree_count;
  logic [BCNT_W-1:0]  box_count;
  logic [CNT_W-1:0]   goal_hits;
  logic [COST_W-1:0]  lead_cost;
  logic [IDX_W-1:0]   lead_index;

  // work registers
  logic [IDX_W-1:0]    idx;
  logic [1:0]          pass;
  logic [D2_W-1:0]     min_d2;
  logic [IDX_W-1:0]    near;
  logic [COORD_W-1:0]  near_x, near_y;
  logic [COST_W-1:0]   near_cost;
  logic [PROD_W-1:0]   sq_a, sq_b, thr2;
  logic [SQ_OUT_W-1:0] dist_q8;
  logic                axis;
  logic [COORD_W-1:0]  new_x, new_y;
  logic [3:0]          status;
  logic [BOX_AW-1:0]   bptr;
  logic [COST_W-1:0]   ncost, bcost;
  logic [IDX_W-1:0]    par, bidx, nidx;
  logic                better;
  logic [IDX_W-1:0]    rewired;
  logic                hit;

  // memories
  logic              tree_we;
  logic [IDX_W-1:0]  tree_waddr;
  node_t             tree_wdata;
  logic [NODE_W-1:0] tree_rdata;
  node_t             rd;
  logic              box_we;
  logic [BOX_W-1:0]  box_rdata;
  box_t              bx;

  assign rd = node_t'(tree_rdata);
  assign bx = box_t'(box_rdata);

  rrt_ram #(.W(NODE_W), .D(MAX_NODES)) u_tree (
    .clk(clk), .we(tree_we), .waddr(tree_waddr), .wdata(NODE_W'(tree_wdata)),
    .re(state == S_RD), .raddr(idx), .rdata(tree_rdata)
  );

  rrt_ram #(.W(BOX_W), .D(MAX_BOXES)) u_box (
    .clk(clk), .we(box_we), .waddr(box_count[BOX_AW-1:0]),
    .wdata({bye, bxe, py, px}), .re(state == S_BRD), .raddr(bptr),
    .rdata(box_rdata)
  );

  // shared units
  logic                sq_start, sq_done;
  logic [SQ_IN_W-1:0]  sq_in;
  logic [SQ_OUT_W-1:0] sq_root;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_q;

  rrt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  rrt_div u_div (
    .clk(clk), .rst(rst), .start(state == S_GDIV),
    .dividend({sq_a[2*COORD_W-1:0], 8'b0}), .divisor(dist_q8),
    .done(div_done), .quotient(div_q)
  );

  // combinational helpers
  logic [COORD_W-1:0]  rx, ry, dax, day;
  logic [COORD_W-1:0]  g_from, g_to, g_mag, gdx, gdy;
  logic [COORD_W:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [D2_W-1:0]     d2;
  logic                last;
  logic                nbr;
  logic [COST_W-1:0]   c_par, c_wire;
  logic signed [22:0]  pos, posc;
  logic [COORD_W:0]    coord, lim_x, lim_y;
  logic                off;
  logic                in_box;

  always_comb begin
    rx  = (pass == P_NEAR) ? px : new_x;
    ry  = (pass == P_NEAR) ? py : new_y;
    dax = (rx > rd.x) ? rx - rd.x : rd.x - rx;
    day = (ry > rd.y) ? ry - rd.y : rd.y - ry;
    gdx = (new_x > goal_x) ? new_x - goal_x : goal_x - new_x;
    gdy = (new_y > goal_y) ? new_y - goal_y : goal_y - new_y;
    g_from = axis ? near_y : near_x;
    g_to   = axis ? py : px;
    g_mag  = (g_to > g_from) ? g_to - g_from : g_from - g_to;

    unique case (state)
      S_MX:    begin mul_a = {1'b0, dax};  mul_b = {1'b0, dax};  end
      S_MY:    begin mul_a = {1'b0, day};  mul_b = {1'b0, day};  end
      S_GMUL:  begin mul_a = {1'b0, g_mag}; mul_b = {1'b0, step}; end
      S_TMUL:  begin mul_a = {step, 1'b0}; mul_b = {step, 1'b0}; end
      S_GX:    begin mul_a = {1'b0, gdx};  mul_b = {1'b0, gdx};  end
      S_GY:    begin mul_a = {1'b0, gdy};  mul_b = {1'b0, gdy};  end
      default: begin mul_a = {1'b0, step}; mul_b = {1'b0, step}; end
    endcase
    mul_p = mul_a * mul_b;

    d2   = D2_W'(sq_a + sq_b);
    last = ({1'b0, idx} + 1'b1) == tree_count;
    nbr  = (d2 != '0) && ({1'b0, d2} < thr2);

    c_par  = sat_add(rd.cost, sq_root);
    c_wire = sat_add(ncost, sq_root);

    // growth: Q8 position, truncated toward zero
    pos  = $signed({3'b0, g_from, 8'b0});
    pos  = (g_to < g_from) ? pos - $signed({3'b0, div_q[19:0]})
                           : pos + $signed({3'b0, div_q[19:0]});
    posc = pos[22] ? '0 : pos;
    coord = posc[20:8];
    lim_x = (map_w > COORD_SPAN) ? COORD_SPAN : map_w;
    lim_y = (map_h > COORD_SPAN) ? COORD_SPAN : map_h;
    off = (pos < -23'sd255) || (coord >= (axis ? lim_y : lim_x));

    in_box = (new_x >= bx.x1) && (new_x <= bx.x2) &&
             (new_y >= bx.y1) && (new_y <= bx.y2);

    sq_start = 1'b0;
    sq_in    = {{(SQ_IN_W - D2_W){1'b0}}, d2};
    if (state == S_CLOSE) begin
      sq_start = (min_d2 != '0) && (min_d2 >= {{(D2_W - COORD_W){1'b0}}, step});
      sq_in    = {{(SQ_IN_W - D2_W - 16){1'b0}}, min_d2, 16'b0};
    end else if (state == S_CSQ) begin
      sq_start = 1'b1;
      sq_in    = {{(SQ_IN_W - D2_W){1'b0}}, min_d2};
    end else if (state == S_EVAL) begin
      sq_start = (pass != P_NEAR) && nbr;
    end

    tree_we    = 1'b0;
    tree_waddr = idx;
    tree_wdata = '{cost: c_wire, parent: tree_count[IDX_W-1:0], y: rd.y, x: rd.x};
    if (state == S_DISP && cmd == CMD_RESTART) begin
      tree_we    = 1'b1;
      tree_waddr = '0;
      tree_wdata = '{cost: '0, parent: '0, y: start_y, x: start_x};
    end else if (state == S_NSW && sq_done && pass == P_WIRE) begin
      tree_we = c_wire < rd.cost;
    end else if (state == S_STORE) begin
      tree_we    = 1'b1;
      tree_waddr = tree_count[IDX_W-1:0];
      tree_wdata = '{cost: ncost, parent: par, y: new_y, x: new_x};
    end

    box_we = (state == S_DISP) && (cmd == CMD_BOX) &&
             (box_count < BCNT_W'(MAX_BOXES));
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      map_w      <= COORD_SPAN;
      map_h      <= COORD_SPAN;
      step       <= 12'd5;
      start_x    <= '0;
      start_y    <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      star_en    <= 1'b1;
      tree_count <= '0;
      box_count  <= '0;
      goal_hits  <= '0;
      lead_cost  <= '0;
      lead_index <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAP_W:   map_w   <= cfg_data;
          CFG_MAP_H:   map_h   <= cfg_data;
          CFG_STEP:    step    <= cfg_data[COORD_W-1:0];
          CFG_START_X: start_x <= cfg_data[COORD_W-1:0];
          CFG_START_Y: start_y <= cfg_data[COORD_W-1:0];
          CFG_GOAL_X:  goal_x  <= cfg_data[COORD_W-1:0];
          CFG_GOAL_Y:  goal_y  <= cfg_data[COORD_W-1:0];
          CFG_STAR:    star_en <= cfg_data[0];
          default: ;
        endcase
      end

      // output slot: loaded from S_DONE when free, cleared when taken
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd     <= s_tuser;
            px      <= s_tdata[11:0];
            py      <= s_tdata[23:12];
            bxe     <= s_tdata[35:24];
            bye     <= s_tdata[47:36];
            status  <= ST_ADDED;
            rewired <= '0;
            hit     <= 1'b0;
            state   <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd)
            CMD_RESTART: begin
              tree_count <= CNT_W'(1);
              box_count  <= '0;
              goal_hits  <= '0;
              lead_cost  <= '0;
              lead_index <= '0;
              status     <= ST_RESTART;
              state      <= S_DONE;
            end
            CMD_BOX: begin
              if (box_we) begin
                box_count <= box_count + 1'b1;
                status    <= ST_BOX_OK;
              end else begin
                status <= ST_BOX_FULL;
              end
              state <= S_DONE;
            end
            CMD_SAMPLE: begin
              if (tree_count == '0) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else if (tree_count == CNT_W'(MAX_NODES)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                pass  <= P_NEAR;
                idx   <= '0;
                state <= S_RD;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_RD: state <= S_MX;
        S_MX: begin
          sq_a  <= mul_p;
          state <= S_MY;
        end
        S_MY: begin
          sq_b  <= mul_p;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (pass == P_NEAR) begin
            if (idx == '0 || d2 < min_d2) begin
              min_d2    <= d2;
              near      <= idx;
              near_x    <= rd.x;
              near_y    <= rd.y;
              near_cost <= rd.cost;
            end
            state <= S_NEXT;
          end else begin
            state <= nbr ? S_NSW : S_NEXT;
          end
        end
        S_NSW: begin
          if (sq_done) begin
            if (pass == P_PAR) begin
              if (c_par < ncost && (!better || c_par < bcost)) begin
                better <= 1'b1;
                bcost  <= c_par;
                bidx   <= idx;
              end
            end else if (tree_we) begin
              rewired <= rewired + 1'b1;
            end
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!last) begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end else if (pass == P_NEAR) begin
            state <= S_CLOSE;
          end else if (pass == P_PAR && better) begin
            par   <= bidx;
            ncost <= bcost;
            pass  <= P_WIRE;
            idx   <= '0;
            state <= S_RD;
          end else begin
            state <= S_STORE;
          end
        end
        S_CLOSE: begin
          if (sq_start) begin
            state <= S_QW;
          end else begin
            status <= ST_CLOSE;
            state  <= S_DONE;
          end
        end
        S_QW: begin
          if (sq_done) begin
            dist_q8 <= sq_root;
            axis    <= 1'b0;
            state   <= S_GMUL;
          end
        end
        S_GMUL: begin
          sq_a  <= mul_p;
          state <= S_GDIV;
        end
        S_GDIV: state <= S_GDW;
        S_GDW: begin
          if (div_done) begin
            if (off) begin
              status <= ST_OFFMAP;
              state  <= S_DONE;
            end else if (!axis) begin
              new_x <= coord[COORD_W-1:0];
              axis  <= 1'b1;
              state <= S_GMUL;
            end else begin
              new_y <= coord[COORD_W-1:0];
              bptr  <= '0;
              state <= (box_count == '0) ? S_CSQ : S_BRD;
            end
          end
        end
        S_BRD: state <= S_BCHK;
        S_BCHK: begin
          if (in_box) begin
            status <= ST_COLLIDE;
            state  <= S_DONE;
          end else if (({1'b0, bptr} + 1'b1) == box_count) begin
            state <= S_CSQ;
          end else begin
            bptr  <= bptr + 1'b1;
            state <= S_BRD;
          end
        end
        S_CSQ: state <= S_CSW;
        S_CSW: begin
          if (sq_done) begin
            ncost  <= sat_add(near_cost, sq_root);
            par    <= near;
            better <= 1'b0;
            state  <= star_en ? S_TMUL : S_STORE;
          end
        end
        S_TMUL: begin
          thr2  <= mul_p;
          pass  <= P_PAR;
          idx   <= '0;
          state <= S_RD;
        end
        S_STORE: begin
          nidx       <= tree_count[IDX_W-1:0];
          tree_count <= tree_count + 1'b1;
          state      <= S_GX;
        end
        S_GX: begin
          sq_a  <= mul_p;
          state <= S_GY;
        end
        S_GY: begin
          sq_b  <= mul_p;
          state <= S_GS;
        end
        S_GS: begin
          thr2  <= mul_p;
          state <= S_GCHK;
        end
        S_GCHK: begin
          if ((sq_a + sq_b) < thr2) begin
            hit <= 1'b1;
            if (goal_hits == '0 || ncost < lead_cost) begin
              lead_cost  <= ncost;
              lead_index <= nidx;
            end
            if (goal_hits < GOAL_SAT) begin
              goal_hits <= goal_hits + 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tuser  <= status;
            if (status == ST_ADDED) begin
              m_tdata <= {4'b0, goal_hits, lead_cost, lead_index, hit, rewired,
                          ncost, par, new_y, new_x, nidx};
            end else begin
              m_tdata <= {4'b0, goal_hits, lead_cost, lead_index, 87'b0};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
